### rtl/core/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// No dependencies.
`default_nettype none

package fbpa_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_OWNS  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_REFUSED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_BASE  = 2'd0,
    CFG_SIZE  = 2'd1,
    CFG_COUNT = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  localparam int unsigned BSIZE_W     = 17;
  localparam int unsigned SIZE_W      = 18;
  localparam int unsigned BSIZE_RESET = 64;

endpackage

`default_nettype wire

### rtl/core/fbpa_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the allocator top to map an address offset to a block.
`default_nettype none

module fbpa_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 18
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dsr_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VW:0]   sh;
  logic          ge;
  logic [VW:0]   diff;

  assign sh   = {rem_q, dvd_q[DW-1]};
  assign ge   = sh >= {1'b0, dsr_q};
  assign diff = sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VW-1:0] : sh[VW-1:0];
      dvd_q <= {dvd_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !start_i)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> rem_q < dsr_q)
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

### rtl/core/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator top: LIFO free list in one synchronous RAM.
// Depends on fbpa_pkg and fbpa_div.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// request   in         start_i & !busy_o            mode_i, address_i
// result    out        done_o (one-cycle strobe)    status_o .. failure_count_o
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// Steps: reset request and an alloc on an empty pool stay in idle; alloc
// does a list RAM read if needed, then multiply and add for the address;
// owns multiplies and checks range; free adds the bit-serial index divider.
// Reset: list state comes up as a full pool of MAX_BLOCKS with no clearing
// pass; RAM entries below the untouched mark are never read.
// Results cannot be stalled; busy_o stays high until the result strobe.
// cfg_ready_o is always high; write configuration only while idle.

module fixed_block_pool_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 1024,
  parameter int unsigned ALIGNMENT  = 8,
  parameter int unsigned ADDR_WIDTH = 32,
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1),
  localparam int unsigned CfgW = (ADDR_WIDTH > fbpa_pkg::BSIZE_W) ? ADDR_WIDTH
                                                                   : fbpa_pkg::BSIZE_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [ADDR_WIDTH-1:0] address_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [ADDR_WIDTH-1:0]      block_address_o,
  output logic                       owned_o,
  output logic [CntW-1:0]            spare_blocks_o,
  output logic [CntW-1:0]            used_blocks_o,
  output logic [31:0]                alloc_count_o,
  output logic [31:0]                release_count_o,
  output logic [31:0]                failure_count_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CfgW-1:0]       cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned SzW  = fbpa_pkg::SIZE_W;
  localparam int unsigned PW   = CntW + SzW;
  localparam int unsigned EW   = ((ADDR_WIDTH > PW) ? ADDR_WIDTH : PW) + 1;
  localparam int unsigned MW   = IdxW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_POPRD, S_AMUL, S_AADD, S_RMUL, S_RCHK, S_DIV, S_FCHK
  } state_e;

  // Rounded-up block size; zero counts as one byte.
  function automatic logic [SzW-1:0] eff_size(input logic [fbpa_pkg::BSIZE_W-1:0] s);
    logic [SzW-1:0] t;
    t = (s == '0) ? SzW'(1) : SzW'(s);
    t = t + SzW'(ALIGNMENT - 1);
    return SzW'((t / ALIGNMENT) * ALIGNMENT);
  endfunction

  // Configuration
  logic [ADDR_WIDTH-1:0] base_q;
  logic [SzW-1:0]        size_q;
  logic [CntW-1:0]       bcount_q;

  // Pool state
  state_e                state_q;
  logic [IdxW-1:0]       head_q;
  logic [CntW-1:0]       free_q;
  logic [CntW-1:0]       active_q;
  logic [CntW-1:0]       top_q;     // blocks [0, top_q) untouched since rebuild
  logic [31:0]           alloc_tot_q, rel_tot_q, fail_tot_q;
  logic                  is_free_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [IdxW-1:0]       idx_q;
  logic [PW-1:0]         prod_q;

  // Result
  logic                  done_q;
  logic [2:0]            status_q;
  logic [ADDR_WIDTH-1:0] blk_q;
  logic                  owned_q;

  // List RAM: {allocated, next link}
  logic [MW-1:0]   mem [MAX_BLOCKS];
  logic [MW-1:0]   rd_q;
  logic            mem_re, mem_we;
  logic [IdxW-1:0] mem_raddr, mem_waddr;
  logic [MW-1:0]   mem_wdata;

  logic                  div_start, div_done;
  logic [ADDR_WIDTH-1:0] div_quot;
  logic [IdxW-1:0]       div_idx;
  logic [EW-1:0]         sum_w;
  logic                  in_region;
  logic                  region_pop;
  logic [IdxW-1:0]       region_next;
  logic [CntW-1:0]       clamp_cnt;
  logic                  accept;

  assign accept      = start_i && (state_q == S_IDLE);
  assign sum_w       = EW'(base_q) + EW'(prod_q);
  assign in_region   = (addr_q >= base_q) && (EW'(addr_q) < sum_w);
  assign region_pop  = (top_q != '0) && (CntW'(head_q) == top_q - 1'b1);
  assign region_next = (head_q == '0) ? '0 : head_q - 1'b1;
  assign div_idx     = div_quot[IdxW-1:0];
  assign clamp_cnt   = (bcount_q == '0) ? CntW'(1)
                     : (bcount_q > CntW'(MAX_BLOCKS)) ? CntW'(MAX_BLOCKS) : bcount_q;

  fbpa_div #(.DW(ADDR_WIDTH), .VW(SzW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (addr_q - base_q),
    .divisor_i  (size_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = head_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = {1'b1, rd_q[IdxW-1:0]};
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && mode_i == fbpa_pkg::MODE_ALLOC && free_q != '0) begin
          if (region_pop) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, region_next};
          end else begin
            mem_re = 1'b1;
          end
        end
      end
      S_POPRD: mem_we = 1'b1;
      S_RCHK: div_start = is_free_q && in_region;
      S_DIV: begin
        mem_raddr = div_idx;
        mem_re    = div_done && (CntW'(div_idx) >= top_q);
      end
      S_FCHK: begin
        mem_waddr = idx_q;
        mem_wdata = {1'b0, head_q};
        mem_we    = rd_q[IdxW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      size_q   <= eff_size(fbpa_pkg::BSIZE_W'(fbpa_pkg::BSIZE_RESET));
      bcount_q <= CntW'(MAX_BLOCKS);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fbpa_pkg::CFG_BASE:  base_q   <= cfg_data_i[ADDR_WIDTH-1:0];
        fbpa_pkg::CFG_SIZE:  size_q   <= eff_size(cfg_data_i[fbpa_pkg::BSIZE_W-1:0]);
        fbpa_pkg::CFG_COUNT: bcount_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= IdxW'(MAX_BLOCKS - 1);
      free_q      <= CntW'(MAX_BLOCKS);
      active_q    <= CntW'(MAX_BLOCKS);
      top_q       <= CntW'(MAX_BLOCKS);
      alloc_tot_q <= '0;
      rel_tot_q   <= '0;
      fail_tot_q  <= '0;
      done_q      <= 1'b0;
      status_q    <= fbpa_pkg::ST_OK;
      blk_q       <= '0;
      owned_q     <= 1'b0;
      is_free_q   <= 1'b0;
      addr_q      <= '0;
      idx_q       <= '0;
      prod_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            addr_q    <= address_i;
            is_free_q <= (mode_i == fbpa_pkg::MODE_FREE);
            status_q  <= fbpa_pkg::ST_OK;
            blk_q     <= '0;
            owned_q   <= 1'b0;
            case (fbpa_pkg::mode_e'(mode_i))
              fbpa_pkg::MODE_ALLOC: begin
                if (free_q == '0) begin
                  status_q   <= fbpa_pkg::ST_EMPTY;
                  fail_tot_q <= fail_tot_q + 1'b1;
                  done_q     <= 1'b1;
                end else begin
                  idx_q       <= head_q;
                  free_q      <= free_q - 1'b1;
                  alloc_tot_q <= alloc_tot_q + 1'b1;
                  if (region_pop) begin
                    head_q  <= region_next;
                    top_q   <= top_q - 1'b1;
                    state_q <= S_AMUL;
                  end else begin
                    state_q <= S_POPRD;
                  end
                end
              end
              fbpa_pkg::MODE_RESET: begin
                done_q <= 1'b1;
                if (free_q != active_q) begin
                  status_q <= fbpa_pkg::ST_REFUSED;
                end else begin
                  active_q    <= clamp_cnt;
                  free_q      <= clamp_cnt;
                  top_q       <= clamp_cnt;
                  head_q      <= IdxW'(clamp_cnt - 1'b1);
                  alloc_tot_q <= '0;
                  rel_tot_q   <= '0;
                  fail_tot_q  <= '0;
                end
              end
              default: state_q <= S_RMUL;   // free and owns start with the range check
            endcase
          end
        end
        S_POPRD: begin
          head_q  <= rd_q[IdxW-1:0];
          state_q <= S_AMUL;
        end
        S_AMUL: begin
          prod_q  <= PW'(idx_q * size_q);
          state_q <= S_AADD;
        end
        S_AADD: begin
          blk_q   <= sum_w[ADDR_WIDTH-1:0];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RMUL: begin
          prod_q  <= PW'(active_q * size_q);
          state_q <= S_RCHK;
        end
        S_RCHK: begin
          owned_q <= in_region;
          if (is_free_q && in_region) begin
            state_q <= S_DIV;
          end else begin
            if (is_free_q) status_q <= fbpa_pkg::ST_RANGE;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            idx_q <= div_idx;
            if (CntW'(div_idx) >= top_q) begin
              state_q <= S_FCHK;
            end else begin
              // never popped since rebuild, so cannot be allocated
              status_q <= fbpa_pkg::ST_NOT_ALLOC;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_FCHK: begin
          if (rd_q[IdxW]) begin
            head_q    <= idx_q;
            free_q    <= free_q + 1'b1;
            rel_tot_q <= rel_tot_q + 1'b1;
          end else begin
            status_q <= fbpa_pkg::ST_NOT_ALLOC;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign block_address_o = blk_q;
  assign owned_o         = owned_q;
  assign spare_blocks_o  = free_q;
  assign used_blocks_o   = active_q - free_q;
  assign alloc_count_o   = alloc_tot_q;
  assign release_count_o = rel_tot_q;
  assign failure_count_o = fail_tot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) free_q <= active_q)
    else $error("free count above pool size");
  assert property (@(posedge clk_i) disable iff (!rst_ni) top_q <= free_q)
    else $error("untouched blocks exceed free count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> state_q == S_IDLE)
    else $error("result strobe while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FCHK) |-> CntW'(idx_q) < active_q)
    else $error("freed index beyond active pool");

endmodule

`default_nettype wire
